// ===== rtl/nelr_pkg.sv =====
// Shared types, codes and sizes for the note event loop recorder.
// No dependencies; every other file in rtl/ but nelr_ram imports this package.
`default_nettype none
package nelr_pkg;

    // Sizing
    localparam int EVENT_DEPTH   = 256;
    localparam int NOTE_COUNT    = 128;
    localparam int QUARTER_TICKS = 24;
    localparam int HALF_TICKS    = QUARTER_TICKS / 2;

    localparam int TIME_W     = 32;
    localparam int NOTE_W     = 7;
    localparam int ACT_W      = 4;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = $clog2(EVENT_DEPTH);
    localparam int MAP_W      = $clog2(NOTE_COUNT);
    localparam int NOTE_CNT_W = NOTE_W + 1;
    localparam int REM_W      = $clog2(QUARTER_TICKS);
    // Sum of the four bytes of the tick count shifted right by three
    localparam int DSUM_W     = 10;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EVENT_DEPTH - 1);

    // Input action codes
    localparam logic [ACT_W-1:0] ACT_TICK       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_START_REC  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_NULL_FIRST = 4'd2;
    localparam logic [ACT_W-1:0] ACT_NOTE_START = 4'd3;
    localparam logic [ACT_W-1:0] ACT_NOTE_STOP  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_STOP_REC   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_REWIND     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_PLAY       = 4'd7;
    localparam logic [ACT_W-1:0] ACT_CLR_AUTO   = 4'd8;

    // Output command codes
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 2'd3;

    typedef enum logic [1:0] {
        KIND_NULL,
        KIND_START,
        KIND_STOP,
        KIND_END
    } t_kind;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [NOTE_W-1:0] ev_note;
        t_kind             ev_kind;
    } t_event;

    localparam int EVENT_W = $bits(t_event);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUANT,
        S_EXEC
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch the item and read the event memory
        logic rem_step;  // one step of the quantizer remainder
        logic exec;      // apply the item and issue its result
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic quant_req; // stop record with quantizing on
        logic rem_last;  // last remainder step in progress
    } t_ctl_status;

endpackage
`default_nettype wire

// ===== rtl/note_event_loop_recorder_unit.sv =====
// Top level of the note event loop recorder: controller plus datapath.
// Depends on nelr_pkg, nelr_ctrl, nelr_datapath (and nelr_ram below it).
`default_nettype none
// Looping note recorder. Issue one action per transfer with start while busy is
// low. Every action yields exactly one result, shown for a single cycle with
// o_strobe high; the receiver must take it then. o_auto_stop, o_loop_length and
// o_current_time always show the live state, which matches the result during
// the strobe cycle. Most actions pass from transfer to the next possible transfer
// through accept (with an event memory read) and then execute, and the
// result strobes in the cycle after execute. A stop record with clock
// quantizing enabled runs quantize steps that reduce the tick count
// modulo 24 (sum the bytes above bit 2 modulo 3, then join the low three bits)
// before the rounded end marker is written. The event memory is not cleared at
// reset; playing entries never recorded gives unspecified notes. Write
// clock_quantize only while the block is idle.
module note_event_loop_recorder_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [nelr_pkg::ACT_W-1:0]  i_action,
    input  wire logic [nelr_pkg::NOTE_W-1:0] i_note,
    input  wire logic                        i_physical_held,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data,
    output logic                             o_strobe,
    output logic [nelr_pkg::CMD_W-1:0]       o_command,
    output logic [nelr_pkg::NOTE_W-1:0]      o_command_note,
    output logic                             o_auto_stop,
    output logic [nelr_pkg::IDX_W-1:0]       o_loop_length,
    output logic [nelr_pkg::TIME_W-1:0]      o_current_time
);
    import nelr_pkg::*;

    t_ctl_cmd    ctl_cmd;
    t_ctl_status ctl_status;

    // Sequence each transfer: accept, optional quantize steps, execute
    nelr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (ctl_status),
        .o_busy   (busy),
        .o_cmd    (ctl_cmd)
    );

    // Hold all recorder state and the event memory
    nelr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_status        (ctl_status),
        .i_action        (i_action),
        .i_note          (i_note),
        .i_physical_held (i_physical_held),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_command       (o_command),
        .o_command_note  (o_command_note),
        .o_auto_stop     (o_auto_stop),
        .o_loop_length   (o_loop_length),
        .o_current_time  (o_current_time)
    );

    // A result strobes only once the controller is back to accepting
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while controller busy");

    // The tick count only moves with a result
    a_time_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_current_time) |-> o_strobe)
        else $error("current time changed without a result");

    // All notes off always restarts time and carries no note
    a_all_off_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_command == CMD_ALL_OFF) |-> (o_current_time == '0)
                                                   && (o_command_note == '0))
        else $error("all notes off without time restart");

    // The full flag only rises with a result
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_auto_stop) |-> o_strobe)
        else $error("auto stop rose without a result");

endmodule
`default_nettype wire

// ===== rtl/nelr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nelr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/nelr_ctrl.sv =====
// Sequencing state machine for the note event loop recorder.
// Depends on nelr_pkg.
`default_nettype none
module nelr_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire nelr_pkg::t_ctl_status i_status,
    output logic                       o_busy,
    output nelr_pkg::t_ctl_cmd         o_cmd
);
    import nelr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_status.quant_req ? S_QUANT : S_EXEC;
                end
            end
            S_QUANT: begin
                o_cmd.rem_step = 1'b1;
                if (i_status.rem_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/nelr_datapath.sv =====
// Datapath: event memory, indexes, tick counter, sounding map, quantizer.
// Depends on nelr_pkg and nelr_ram.
`default_nettype none
module nelr_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire nelr_pkg::t_ctl_cmd           i_cmd,
    output nelr_pkg::t_ctl_status             o_status,
    input  wire logic [nelr_pkg::ACT_W-1:0]   i_action,
    input  wire logic [nelr_pkg::NOTE_W-1:0]  i_note,
    input  wire logic                         i_physical_held,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_data,
    output logic                              o_strobe,
    output logic [nelr_pkg::CMD_W-1:0]        o_command,
    output logic [nelr_pkg::NOTE_W-1:0]       o_command_note,
    output logic                              o_auto_stop,
    output logic [nelr_pkg::IDX_W-1:0]        o_loop_length,
    output logic [nelr_pkg::TIME_W-1:0]       o_current_time
);
    import nelr_pkg::*;

    // Control state
    logic                  r_quantize;
    logic [IDX_W-1:0]      r_idx,   n_idx;
    logic [TIME_W-1:0]     r_tick,  n_tick;
    logic [IDX_W-1:0]      r_end,   n_end;
    logic                  r_full,  n_full;
    logic [NOTE_COUNT-1:0] r_map,   n_map;
    logic                  r_strobe;

    // Captured item and result payload
    logic [ACT_W-1:0]      r_action;
    logic [NOTE_W-1:0]     r_note;
    logic                  r_held;
    logic [CMD_W-1:0]      r_cmd,   n_cmd;
    logic [NOTE_W-1:0]     r_cnote, n_cnote;

    // Quantizer: tick count modulo a quarter note in two steps. Since
    // t = 8a + b, t mod 24 = 8 * (a mod 3) + b; fold the bytes of a modulo 3.
    logic [REM_W-1:0]      r_rem;
    logic                  r_pos;
    logic [DSUM_W-1:0]     r_dsum;
    logic [TIME_W-1:0]     tick_hi;
    logic [DSUM_W-1:0]     byte_sum;
    logic [TIME_W-1:0]     q_base;
    logic [TIME_W-1:0]     end_time;

    // Event memory ports
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    t_event                wdata;
    logic [EVENT_W-1:0]    rdata_raw;
    t_event                rd_ev;

    logic                  log_ok;
    logic                  note_ok;
    logic                  rd_note_ok;
    logic [MAP_W-1:0]      note_sel;
    logic [MAP_W-1:0]      rd_sel;
    logic [IDX_W-1:0]      adv_idx;
    logic [IDX_W:0]        play_next;

    // Reduce a byte sum modulo 3 (16 and 4 are both 1 modulo 3)
    function automatic logic [1:0] fold_mod3(input logic [DSUM_W-1:0] s);
        logic [5:0] f1;
        logic [3:0] f2;
        f1 = 6'(s[3:0]) + 6'(s[7:4]) + 6'(s[9:8]);
        f2 = 4'(f1[1:0]) + 4'(f1[3:2]) + 4'(f1[5:4]);
        if (f2 >= 4'd6) begin
            return 2'(f2 - 4'd6);
        end else if (f2 >= 4'd3) begin
            return 2'(f2 - 4'd3);
        end
        return f2[1:0];
    endfunction

    nelr_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (EVENT_DEPTH)
    ) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (r_idx),
        .o_rdata (rdata_raw)
    );

    assign rd_ev       = t_event'(rdata_raw);
    assign o_cfg_ready = 1'b1;

    assign o_status.quant_req = (i_action == ACT_STOP_REC) && r_quantize;
    assign o_status.rem_last  = !r_pos;

    assign tick_hi  = r_tick >> 3;
    assign byte_sum = (DSUM_W'(tick_hi[7:0]) + DSUM_W'(tick_hi[15:8]))
                    + (DSUM_W'(tick_hi[23:16]) + DSUM_W'(tick_hi[31:24]));
    assign q_base   = r_tick - TIME_W'(r_rem);
    assign end_time = !r_quantize ? r_tick :
                      (r_rem > REM_W'(HALF_TICKS)) ? q_base + TIME_W'(QUARTER_TICKS) : q_base;

    assign log_ok     = (r_idx < IDX_LAST);
    assign note_ok    = ({1'b0, r_note} < NOTE_CNT_W'(NOTE_COUNT));
    assign rd_note_ok = ({1'b0, rd_ev.ev_note} < NOTE_CNT_W'(NOTE_COUNT));
    assign note_sel   = r_note[MAP_W-1:0];
    assign rd_sel     = rd_ev.ev_note[MAP_W-1:0];
    assign adv_idx    = r_idx + 1'b1;
    assign play_next  = {1'b0, r_idx} + 1'b1;

    always_comb begin
        n_idx   = r_idx;
        n_tick  = r_tick;
        n_end   = r_end;
        n_full  = r_full;
        n_map   = r_map;
        n_cmd   = CMD_NONE;
        n_cnote = '0;
        we      = 1'b0;
        waddr   = r_idx;
        wdata   = '{ev_time: r_tick, ev_note: r_note, ev_kind: KIND_START};
        if (i_cmd.exec) begin
            case (r_action)
                ACT_TICK: begin
                    n_tick = r_tick + 1'b1;
                end
                ACT_START_REC, ACT_REWIND: begin
                    n_tick = '0;
                    n_idx  = '0;
                end
                ACT_NULL_FIRST: begin
                    if (log_ok) begin
                        we     = 1'b1;
                        waddr  = '0;
                        wdata  = '{ev_time: '0, ev_note: '0, ev_kind: KIND_NULL};
                        n_idx  = adv_idx;
                        if (adv_idx == IDX_LAST) begin
                            n_full = 1'b1;
                        end
                    end
                end
                ACT_NOTE_START, ACT_NOTE_STOP: begin
                    if (log_ok && note_ok) begin
                        we    = 1'b1;
                        wdata = '{ev_time: r_tick, ev_note: r_note,
                                  ev_kind: (r_action == ACT_NOTE_START) ? KIND_START
                                                                        : KIND_STOP};
                        n_map[note_sel] = (r_action == ACT_NOTE_START);
                        n_idx = adv_idx;
                        if (adv_idx == IDX_LAST) begin
                            n_full = 1'b1;
                        end
                    end
                end
                ACT_STOP_REC: begin
                    we     = 1'b1;
                    wdata  = '{ev_time: end_time, ev_note: '0, ev_kind: KIND_END};
                    n_end  = r_idx;
                    n_idx  = '0;
                    n_tick = '0;
                    n_map  = '0;
                    n_cmd  = CMD_ALL_OFF;
                end
                ACT_PLAY: begin
                    if (r_tick >= rd_ev.ev_time) begin
                        if (rd_ev.ev_kind == KIND_START && !r_held && rd_note_ok) begin
                            n_map[rd_sel] = 1'b1;
                            n_cmd   = CMD_NOTE_ON;
                            n_cnote = rd_ev.ev_note;
                        end else if (rd_ev.ev_kind == KIND_STOP && rd_note_ok
                                     && r_map[rd_sel]) begin
                            n_map[rd_sel] = 1'b0;
                            n_cmd   = CMD_NOTE_OFF;
                            n_cnote = rd_ev.ev_note;
                        end
                        // Wrap past the end marker overrides any note command
                        if (play_next > {1'b0, r_end}) begin
                            n_idx   = '0;
                            n_tick  = '0;
                            n_map   = '0;
                            n_cmd   = CMD_ALL_OFF;
                            n_cnote = '0;
                        end else begin
                            n_idx = play_next[IDX_W-1:0];
                        end
                    end
                end
                ACT_CLR_AUTO: begin
                    n_full = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantize <= 1'b0;
            r_idx      <= '0;
            r_tick     <= '0;
            r_end      <= '0;
            r_full     <= 1'b0;
            r_map      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantize <= i_cfg_data;
            end
            r_idx    <= n_idx;
            r_tick   <= n_tick;
            r_end    <= n_end;
            r_full   <= n_full;
            r_map    <= n_map;
            r_strobe <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_note   <= i_note;
            r_held   <= i_physical_held;
            r_rem    <= '0;
            r_pos    <= 1'b1;
        end else if (i_cmd.rem_step) begin
            // First step: sum the bytes; second step: join the low three bits
            if (r_pos) begin
                r_dsum <= byte_sum;
            end else begin
                r_rem <= {fold_mod3(r_dsum), r_tick[2:0]};
            end
            r_pos <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_cmd   <= n_cmd;
            r_cnote <= n_cnote;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_command      = r_cmd;
    assign o_command_note = r_cnote;
    assign o_auto_stop    = r_full;
    assign o_loop_length  = r_end;
    assign o_current_time = r_tick;

endmodule
`default_nettype wire

// ===== tb/sv/tb_note_event_loop_recorder_unit.sv =====
// Self-checking testbench for note_event_loop_recorder_unit: a short directed table, then
// recording/playback episodes with random content, each result checked against a predictor.
// Depends on nelr_pkg and the RTL of the note event loop recorder.
`timescale 1ns / 1ps

module tb_note_event_loop_recorder_unit;
    import nelr_pkg::*;

    // Action codes that the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    // One result of the block, in port order
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NOTE_W-1:0] cnote;
        logic              auto_stop;
        logic [IDX_W-1:0]  loop_len;
        logic [TIME_W-1:0] now;
    } t_result;

    // One row of the directed table; typed_exp marks rows whose result is written out
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [NOTE_W-1:0] note;
        logic              held;
        logic              typed_exp;
        t_result           exp;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [ACT_W-1:0]     i_action;
    logic [NOTE_W-1:0]    i_note;
    logic                 i_physical_held;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_data;
    logic                 o_strobe;
    logic [CMD_W-1:0]     o_command;
    logic [NOTE_W-1:0]    o_command_note;
    logic                 o_auto_stop;
    logic [IDX_W-1:0]     o_loop_length;
    logic [TIME_W-1:0]    o_current_time;

    note_event_loop_recorder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_note          (i_note),
        .i_physical_held (i_physical_held),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_command       (o_command),
        .o_command_note  (o_command_note),
        .o_auto_stop     (o_auto_stop),
        .o_loop_length   (o_loop_length),
        .o_current_time  (o_current_time)
    );

    // Predicted state of the recorder
    logic [TIME_W-1:0]     ev_time [EVENT_DEPTH];
    logic [NOTE_W-1:0]     ev_note [EVENT_DEPTH];
    t_kind                 ev_kind [EVENT_DEPTH];
    bit [EVENT_DEPTH-1:0]  ev_written;
    int unsigned           log_idx;
    logic [TIME_W-1:0]     ticks;
    int unsigned           end_idx;
    bit                    full_flag;
    logic [NOTE_COUNT-1:0] sounding;
    bit                    quantize_on;

    t_result loop_results_due[$];
    t_row    stim_rows[$];
    int      mismatches;
    int      items_sent;
    int      idle_pct;
    int      cycles;

    // Clock: 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: end the run if the block stops producing results
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Advance the log index under the full-table rule
    function automatic void advance_log_index();
        if (log_idx < EVENT_DEPTH - 1) begin
            log_idx++;
            if (log_idx == EVENT_DEPTH - 1) full_flag = 1'b1;
        end
    endfunction

    // Apply one accepted action to the predicted state and return its result
    function automatic t_result predict_loop_step(logic [ACT_W-1:0] act,
                                                  logic [NOTE_W-1:0] n, logic held);
        t_result           r;
        logic [TIME_W-1:0] q;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] t_end;
        t_kind             k;
        logic [NOTE_W-1:0] nn;
        r = '0;
        case (act)
            ACT_TICK: ticks = ticks + 1;
            ACT_START_REC: begin
                ticks   = '0;
                log_idx = 0;
            end
            ACT_NULL_FIRST: begin
                if (log_idx < EVENT_DEPTH - 1) begin
                    ev_time[0]    = '0;
                    ev_note[0]    = '0;
                    ev_kind[0]    = KIND_NULL;
                    ev_written[0] = 1'b1;
                    advance_log_index();
                end
            end
            ACT_NOTE_START, ACT_NOTE_STOP: begin
                // drop logs once the table is full
                if (log_idx < EVENT_DEPTH - 1) begin
                    ev_time[log_idx]    = ticks;
                    ev_note[log_idx]    = n;
                    ev_kind[log_idx]    = (act == ACT_NOTE_START) ? KIND_START : KIND_STOP;
                    ev_written[log_idx] = 1'b1;
                    sounding[n]         = (act == ACT_NOTE_START);
                    advance_log_index();
                end
            end
            ACT_STOP_REC: begin
                t_end = ticks;
                if (quantize_on) begin
                    // round to the nearest quarter note, exact half rounds down
                    q     = ticks / QUARTER_TICKS;
                    rem   = ticks - q * QUARTER_TICKS;
                    t_end = (rem > HALF_TICKS) ? (q + 1) * QUARTER_TICKS : q * QUARTER_TICKS;
                end
                ev_time[log_idx]    = t_end;
                ev_note[log_idx]    = '0;
                ev_kind[log_idx]    = KIND_END;
                ev_written[log_idx] = 1'b1;
                end_idx  = log_idx;
                log_idx  = 0;
                ticks    = '0;
                sounding = '0;
                r.cmd    = CMD_ALL_OFF;
            end
            ACT_REWIND: begin
                log_idx = 0;
                ticks   = '0;
            end
            ACT_PLAY: begin
                if (ticks >= ev_time[log_idx]) begin
                    k  = ev_kind[log_idx];
                    nn = ev_note[log_idx];
                    if (k == KIND_START && !held) begin
                        sounding[nn] = 1'b1;
                        r.cmd        = CMD_NOTE_ON;
                        r.cnote      = nn;
                    end else if (k == KIND_STOP && sounding[nn]) begin
                        sounding[nn] = 1'b0;
                        r.cmd        = CMD_NOTE_OFF;
                        r.cnote      = nn;
                    end
                    log_idx++;
                    // wrap past the end marker: all notes off wins
                    if (log_idx > end_idx) begin
                        log_idx  = 0;
                        ticks    = '0;
                        sounding = '0;
                        r.cmd    = CMD_ALL_OFF;
                        r.cnote  = '0;
                    end
                end
            end
            ACT_CLR_AUTO: full_flag = 1'b0;
            default: ;
        endcase
        r.auto_stop = full_flag;
        r.loop_len  = IDX_W'(end_idx);
        r.now       = ticks;
        return r;
    endfunction

    // Present one action, hold it until the transfer, and queue its expected result.
    // Inputs change at the falling edge; the transfer is sampled at the rising edge.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [NOTE_W-1:0] n,
                             input logic held, input logic typed_exp, input t_result exp);
        bit      accepted;
        t_result due;
        // idle the sender while a random draw falls below idle_pct
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_action        <= act;
        i_note          <= n;
        i_physical_held <= held;
        start           <= 1'b1;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = (start === 1'b1) && (busy === 1'b0);
        end
        due = predict_loop_step(act, n, held);
        loop_results_due.push_back(typed_exp ? exp : due);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_action(input logic [ACT_W-1:0] act, input logic [NOTE_W-1:0] n,
                               input logic held);
        send_item(act, n, held, 1'b0, '0);
    endtask

    // Drain all results, then write clock_quantize over the config channel
    task automatic write_quantize(input logic v);
        bit accepted;
        start <= 1'b0;
        while (loop_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = (o_cfg_ready === 1'b1);
        end
        quantize_on = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [NOTE_W-1:0] n,
                           input logic held, input logic typed_exp,
                           input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] loop_len,
                           input logic [TIME_W-1:0] now);
        t_row row;
        row.act           = act;
        row.note          = n;
        row.held          = held;
        row.typed_exp     = typed_exp;
        row.exp           = '0;
        row.exp.cmd       = cmd;
        row.exp.loop_len  = loop_len;
        row.exp.now       = now;
        stim_rows.push_back(row);
    endtask

    // Note near a per-episode base, sometimes anywhere in range
    function automatic logic [NOTE_W-1:0] pick_note(int unsigned base);
        if ($urandom_range(3) == 0) return NOTE_W'($urandom_range(NOTE_COUNT - 1));
        return NOTE_W'(base + $urandom_range(3));
    endfunction

    // Record a take: start, optional null first event, ticks and notes, stop
    task automatic record_take(input int len);
        int unsigned base;
        int          r;
        base = $urandom_range(NOTE_COUNT - 5);
        send_action(ACT_START_REC, NOTE_W'($urandom), 1'($urandom));
        if ($urandom_range(1)) send_action(ACT_NULL_FIRST, NOTE_W'($urandom), 1'($urandom));
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                repeat ($urandom_range(4, 1)) send_action(ACT_TICK, NOTE_W'($urandom), 1'($urandom));
            end else if (r < 65) begin
                send_action(ACT_NOTE_START, pick_note(base), 1'($urandom));
            end else if (r < 90) begin
                send_action(ACT_NOTE_STOP, pick_note(base), 1'($urandom));
            end else if (r < 95) begin
                send_action($urandom_range(1) ? ACT_CLR_AUTO : ACT_NULL_FIRST,
                            NOTE_W'($urandom), 1'($urandom));
            end else begin
                send_action(ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)),
                            NOTE_W'($urandom), 1'($urandom));
            end
        end
        send_action(ACT_STOP_REC, NOTE_W'($urandom), 1'($urandom));
    endtask

    // Play back the take; play only entries that were written, mixed with ticks and other actions
    task automatic play_take(input int len);
        int r;
        if ($urandom_range(1)) send_action(ACT_REWIND, NOTE_W'($urandom), 1'($urandom));
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 50 && ev_written[log_idx]) begin
                send_action(ACT_PLAY, NOTE_W'($urandom), $urandom_range(3) == 0);
            end else if (r < 85) begin
                send_action(ACT_TICK, NOTE_W'($urandom), 1'($urandom));
            end else if (r < 90) begin
                // overdub while playing
                send_action($urandom_range(1) ? ACT_NOTE_START : ACT_NOTE_STOP,
                            NOTE_W'($urandom), 1'($urandom));
            end else if (r < 95) begin
                send_action($urandom_range(1) ? ACT_CLR_AUTO : ACT_REWIND,
                            NOTE_W'($urandom), 1'($urandom));
            end else begin
                send_action(ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)),
                            NOTE_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // Fill the event table until auto stop, then show that logs stay dropped
    task automatic fill_table();
        bit start_next;
        send_action(ACT_START_REC, '0, 1'b0);
        start_next = 1'b1;
        while (log_idx < EVENT_DEPTH - 1) begin
            if ($urandom_range(9) == 0) begin
                send_action(ACT_TICK, NOTE_W'($urandom), 1'($urandom));
            end else begin
                send_action(start_next ? ACT_NOTE_START : ACT_NOTE_STOP,
                            NOTE_W'($urandom), 1'($urandom));
                start_next = !start_next;
            end
        end
        send_action(ACT_NOTE_START, NOTE_W'($urandom), 1'b0);
        send_action(ACT_CLR_AUTO, NOTE_W'($urandom), 1'b0);
        // still dropped after clear auto stop, until a start record, stop record or rewind
        send_action(ACT_NOTE_STOP, NOTE_W'($urandom), 1'b1);
        send_action(ACT_NULL_FIRST, NOTE_W'($urandom), 1'b0);
        send_action(ACT_STOP_REC, NOTE_W'($urandom), 1'b0);
    endtask

    // Run random episodes at one sender idle rate until the item count is reached
    task automatic run_phase(input int target, input int pct);
        idle_pct = pct;
        target   = items_sent + target;
        while (items_sent < target) begin
            record_take($urandom_range(16, 4));
            play_take($urandom_range(30, 10));
        end
    endtask

    // Check each strobed result against the oldest expectation, field by field
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (loop_results_due.size() == 0) begin
                $display("%0t: result with none expected: cmd %0d note %0d time %0d",
                         $time, o_command, o_command_note, o_current_time);
                mismatches++;
            end else begin
                want = loop_results_due.pop_front();
                check_field("command", 32'(want.cmd), 32'(o_command));
                check_field("command_note", 32'(want.cnote), 32'(o_command_note));
                check_field("auto_stop", 32'(want.auto_stop), 32'(o_auto_stop));
                check_field("loop_length", 32'(want.loop_len), 32'(o_loop_length));
                check_field("current_time", want.now, o_current_time);
            end
        end
    end

    initial begin
        // Drive every input from time zero and hold reset
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_action        = ACT_TICK;
        i_note          = '0;
        i_physical_held = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        idle_pct        = 0;
        ev_written      = '0;
        log_idx         = 0;
        ticks           = '0;
        end_idx         = 0;
        full_flag       = 1'b0;
        sounding        = '0;
        quantize_on     = 1'b0;
        for (int i = 0; i < EVENT_DEPTH; i++) begin
            ev_time[i] = '0;
            ev_note[i] = '0;
            ev_kind[i] = KIND_NULL;
        end

        // Directed take: reset values, ignored actions, a short recording with
        // muted note on, note on/off, a note not yet due, then the wrap.
        add_row(ACT_TICK,       7'd0,   1'b0, 1'b1, CMD_NONE,    8'd0, 32'd1);
        add_row(ACT_UNUSED_HI,  7'd127, 1'b1, 1'b1, CMD_NONE,    8'd0, 32'd1);
        add_row(ACT_UNUSED_LO,  7'd85,  1'b0, 1'b1, CMD_NONE,    8'd0, 32'd1);
        add_row(ACT_CLR_AUTO,   7'd42,  1'b1, 1'b1, CMD_NONE,    8'd0, 32'd1);
        add_row(ACT_START_REC,  7'd0,   1'b0, 1'b1, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NULL_FIRST, 7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_TICK,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NOTE_START, 7'd127, 1'b1, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NOTE_START, 7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_TICK,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NOTE_STOP,  7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NOTE_STOP,  7'd127, 1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_STOP_REC,   7'd0,   1'b0, 1'b1, CMD_ALL_OFF, 8'd5, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_TICK,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b1, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_TICK,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_PLAY,       7'd0,   1'b0, 1'b1, CMD_ALL_OFF, 8'd5, 32'd0);
        add_row(ACT_REWIND,     7'd0,   1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);
        add_row(ACT_NOTE_START, 7'd64,  1'b0, 1'b0, CMD_NONE,    8'd0, 32'd0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_quantize(1'b0);
        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].act, stim_rows[i].note, stim_rows[i].held,
                      stim_rows[i].typed_exp, stim_rows[i].exp);
        end

        // Random phases; each config write first drains every pending result
        write_quantize(1'b1);
        run_phase(30, 7);
        write_quantize(1'b0);
        run_phase(30, 48);
        write_quantize(1'b1);
        idle_pct = 0;
        fill_table();
        play_take(20);
        run_phase(30, 0);

        // Drop start, wait out the last results, then a short drain
        start <= 1'b0;
        while (loop_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nelr_pkg.sv
rtl/nelr_ram.sv
rtl/nelr_ctrl.sv
rtl/nelr_datapath.sv
rtl/note_event_loop_recorder_unit.sv
tb/sv/tb_note_event_loop_recorder_unit.sv
